// ===== rtl/icm_pkg.sv =====
// Shared types, constants and codes for the Ising chain Metropolis block.
`default_nettype none

package icm_pkg;

    // Chain storage and field widths.
    localparam int MAX_SITES   = 1024;
    localparam int ADDR_W      = $clog2(MAX_SITES);
    localparam int LEN_W       = $clog2(MAX_SITES + 1);
    localparam int SITE_W      = 10;
    localparam int RND_W       = 16;
    localparam int RANDOM_BITS = 16;
    localparam logic [RND_W-1:0] RND_MASK = RND_W'((64'd1 << RANDOM_BITS) - 64'd1);
    localparam int TOT_W       = 12;

    // Acceptance table geometry.
    localparam int THR_W     = 16;
    localparam int THR_N     = 10;
    localparam int THR_IDX_W = $clog2(THR_N);

    // Configuration port geometry.
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 6;
    localparam int CFG_IW = 3;

    // Register indexes (byte address is eight times the index).
    localparam logic [CFG_IW-1:0] REG_TABLE_A = 3'd0;
    localparam logic [CFG_IW-1:0] REG_TABLE_B = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TABLE_C = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SITES   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WRAP    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ABS     = 3'd5;

    // Request mode codes.
    localparam logic [2:0] MODE_TRIAL    = 3'd0;
    localparam logic [2:0] MODE_ALL_UP   = 3'd1;
    localparam logic [2:0] MODE_ALL_DOWN = 3'd2;
    localparam logic [2:0] MODE_HALF     = 3'd3;
    localparam logic [2:0] MODE_SET      = 3'd4;

    // One request.
    typedef struct packed {
        logic [2:0]        mode;
        logic [SITE_W-1:0] site;
        logic [RND_W-1:0]  random_word;
        logic              spin_value;
    } t_req;

    // One result.
    typedef struct packed {
        logic                    accepted;
        logic                    spin_after;
        logic signed [TOT_W-1:0] magnetization;
        logic signed [TOT_W-1:0] bond_sum;
        logic                    item_refused;
    } t_res;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [THR_N-1:0][THR_W-1:0] thresholds;
        logic [LEN_W-1:0]            chain_len;
        logic                        wrap;
        logic                        abs_mag;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic rd_right;
        logic item_update;
        logic fill_write;
        logic fill_finish;
        logic clear_pass;
        logic clear_finish;
        logic count_read;
        logic count_finish;
        logic refuse_finish;
        logic cnt_clear;
        logic cnt_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic refused;
        logic is_fill;
        logic cnt_last;
        logic cnt_top;
    } t_dp_sts;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_COUNT_END,
        S_DISPATCH,
        S_READ_R,
        S_UPDATE,
        S_FILL
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/ising_chain_metropolis.sv =====
// Top level of the Metropolis single-spin-flip engine for a 1D Ising chain.
`default_nettype none

// Usage:
//   Requests enter on i_request and are taken at a rising edge where start is
//   high and busy is low. Each request yields one result on o_result, marked by
//   o_done for exactly one cycle; the receiver must take it then.
//   The APB-style port holds the acceptance table, chain length, boundary and
//   absolute-magnetization registers at byte addresses 0, 8, ... 40.
// Sequencing from the accepting edge to the result, by request kind:
//   - trial flip or set site: the site and its left neighbor, then its
//     right neighbor, come through the two read ports of the spin memory.
//   - refused request: the result is formed in the dispatch state.
//   - fill: one memory write per site.
//   Unless a recount is pending, the next request is taken in the cycle its
//   predecessor's result is shown.
// Writing the chain length or the boundary register starts a recount sweep
//   through the spin memory, with busy held high.
// After reset a clearing pass sets all 1024 spins up with busy high;
//   configuration writes are taken during it.
module ising_chain_metropolis import icm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  t_req                   i_request,
    output logic                   o_done,
    output t_res                   o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg    cfg;
    logic    recount;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers.
    icm_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_recount (recount)
    );

    // Sequencing.
    icm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_recount (recount),
        .i_sts     (sts),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    // Spin storage and arithmetic.
    icm_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_req   (i_request),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_res   (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/icm_cfg_regs.sv =====
// Configuration register file with an APB-style write and read port.
`default_nettype none

module icm_cfg_regs import icm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg,
    output logic                   o_recount
);

    logic [63:0]      r_tab_a;
    logic [63:0]      r_tab_b;
    logic [31:0]      r_tab_c;
    logic [10:0]      r_sites;
    logic             r_wrap;
    logic             r_abs;
    logic             wr_en;
    logic [CFG_IW-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_AW-1:3];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_a <= '1;
            r_tab_b <= '1;
            r_tab_c <= '1;
            r_sites <= 11'(MAX_SITES);
            r_wrap  <= 1'b1;
            r_abs   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TABLE_A: r_tab_a <= pwdata;
                REG_TABLE_B: r_tab_b <= pwdata;
                REG_TABLE_C: r_tab_c <= pwdata[31:0];
                REG_SITES:   r_sites <= pwdata[10:0];
                REG_WRAP:    r_wrap  <= pwdata[0];
                REG_ABS:     r_abs   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // A write of length or boundary asks for the totals to be recounted.
    assign o_recount = wr_en && ((reg_idx == REG_SITES) || (reg_idx == REG_WRAP));

    // Read-back mux.
    always_comb begin
        unique case (reg_idx)
            REG_TABLE_A: prdata = r_tab_a;
            REG_TABLE_B: prdata = r_tab_b;
            REG_TABLE_C: prdata = CFG_DW'(r_tab_c);
            REG_SITES:   prdata = CFG_DW'(r_sites);
            REG_WRAP:    prdata = CFG_DW'(r_wrap);
            REG_ABS:     prdata = CFG_DW'(r_abs);
            default:     prdata = '0;
        endcase
    end

    // Chain length saturated to the supported range.
    always_comb begin
        o_cfg.thresholds = {r_tab_c, r_tab_b, r_tab_a};
        o_cfg.wrap       = r_wrap;
        o_cfg.abs_mag    = r_abs;
        if (r_sites < 11'd2) begin
            o_cfg.chain_len = LEN_W'(2);
        end else if (r_sites > 11'(MAX_SITES)) begin
            o_cfg.chain_len = LEN_W'(MAX_SITES);
        end else begin
            o_cfg.chain_len = LEN_W'(r_sites);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/icm_ctrl.sv =====
// Controller state machine sequencing trials, fills, recounts and the clearing pass.
`default_nettype none

module icm_ctrl import icm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_recount,
    input  t_dp_sts      i_sts,
    output logic         o_busy,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_pend;
    logic   n_pend;
    logic   accept;

    assign o_busy = (r_state != S_IDLE) || r_pend;
    assign accept = i_start && !o_busy;

    // State and pending recount registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // A new config write wins over the end of a pass that would clear the flag.
    always_comb begin
        n_pend = r_pend;
        if (i_recount) begin
            n_pend = 1'b1;
        end else if ((r_state == S_CLEAR) && i_sts.cnt_top) begin
            n_pend = 1'b0;
        end else if ((r_state == S_IDLE) && r_pend) begin
            n_pend = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (i_sts.cnt_top) n_state = S_IDLE;
            S_IDLE: begin
                if (r_pend) begin
                    n_state = S_COUNT;
                end else if (accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_COUNT:     if (i_sts.cnt_last) n_state = S_COUNT_END;
            S_COUNT_END: n_state = S_IDLE;
            S_DISPATCH: begin
                if (i_sts.refused) begin
                    n_state = S_IDLE;
                end else if (i_sts.is_fill) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_READ_R;
                end
            end
            S_READ_R:    n_state = S_UPDATE;
            S_UPDATE:    n_state = S_IDLE;
            S_FILL:      if (i_sts.cnt_last) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.fill_write   = 1'b1;
                o_cmd.clear_pass   = 1'b1;
                o_cmd.cnt_step     = 1'b1;
                o_cmd.clear_finish = i_sts.cnt_top;
            end
            S_IDLE: begin
                o_cmd.load_item = accept;
                o_cmd.cnt_clear = 1'b1;
            end
            S_COUNT: begin
                o_cmd.count_read = 1'b1;
                o_cmd.cnt_step   = 1'b1;
            end
            S_COUNT_END: o_cmd.count_finish = 1'b1;
            S_DISPATCH: begin
                o_cmd.cnt_clear     = 1'b1;
                o_cmd.refuse_finish = i_sts.refused;
            end
            S_READ_R:    o_cmd.rd_right = 1'b1;
            S_UPDATE:    o_cmd.item_update = 1'b1;
            S_FILL: begin
                o_cmd.fill_write  = 1'b1;
                o_cmd.cnt_step    = 1'b1;
                o_cmd.fill_finish = i_sts.cnt_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/icm_datapath.sv =====
// Datapath: spin memory, neighbor lookup, acceptance test, totals and result register.
`default_nettype none

module icm_datapath import icm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  t_cfg         i_cfg,
    input  t_dp_cmd      i_cmd,
    input  t_req         i_req,
    output t_dp_sts      o_sts,
    output logic         o_done,
    output t_res         o_res
);

    localparam logic signed [TOT_W-1:0] ONE   = TOT_W'(1);
    localparam logic signed [TOT_W-1:0] TWO   = TOT_W'(2);
    localparam logic signed [TOT_W-1:0] THREE = TOT_W'(3);

    // Spin memory, one bit per site, two registered read ports.
    logic r_spins [MAX_SITES];
    logic r_rd_a;
    logic r_rd_b;

    t_req                    r_req;
    logic [ADDR_W-1:0]       r_cnt;
    logic                    r_old;
    logic                    r_left;
    logic signed [TOT_W-1:0] r_mag;
    logic signed [TOT_W-1:0] r_bond;
    logic signed [TOT_W-1:0] r_acc_m;
    logic signed [TOT_W-1:0] r_acc_b;
    logic                    r_prev;
    logic                    r_first;
    logic                    r_cnt_vld;
    logic                    r_cnt_first;
    t_res                    r_res;
    logic                    r_done;

    logic [LEN_W-1:0]        site_len;
    logic [LEN_W-1:0]        site_inc;
    logic [LEN_W-1:0]        half_len;
    logic                    site_ok;
    logic [ADDR_W-1:0]       site_addr;
    logic [ADDR_W-1:0]       last_addr;
    logic [ADDR_W-1:0]       left_addr;
    logic [ADDR_W-1:0]       right_addr;
    logic                    left_ok;
    logic                    right_ok;
    logic [ADDR_W-1:0]       addr_a;
    logic [ADDR_W-1:0]       addr_b;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic                    mem_wdata;

    logic signed [2:0]       nb_left;
    logic signed [2:0]       nb_right;
    logic signed [2:0]       nsum;
    logic [4:0]              idx_w;
    logic [THR_IDX_W-1:0]    thr_idx;
    logic [THR_W-1:0]        thr;
    logic [RND_W-1:0]        rnd;
    logic                    flip;
    logic                    new_spin;
    logic                    write_item;
    logic                    changed;
    logic signed [TOT_W-1:0] nsum_w;
    logic signed [TOT_W-1:0] bond_step;
    logic signed [TOT_W-1:0] item_mag;
    logic signed [TOT_W-1:0] item_bond;

    logic                    fill_val;
    logic                    fill_after;
    logic signed [TOT_W-1:0] n_s;
    logic signed [TOT_W-1:0] wrap_s;
    logic signed [TOT_W-1:0] up_b;
    logic signed [TOT_W-1:0] fill_m;
    logic signed [TOT_W-1:0] fill_b;

    logic signed [TOT_W-1:0] n_acc_m;
    logic signed [TOT_W-1:0] n_acc_b;
    logic signed [TOT_W-1:0] cnt_b;

    logic signed [TOT_W-1:0] tot_m;
    logic signed [TOT_W-1:0] tot_b;
    logic                    tot_load;
    logic                    res_load;
    t_res                    n_res;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_req <= i_req;
        end
    end

    // Request decode and neighbor addresses.
    always_comb begin
        site_len   = LEN_W'(r_req.site);
        site_inc   = site_len + LEN_W'(1);
        half_len   = i_cfg.chain_len >> 1;
        site_ok    = site_len < i_cfg.chain_len;
        site_addr  = ADDR_W'(r_req.site);
        last_addr  = ADDR_W'(i_cfg.chain_len - LEN_W'(1));
        left_ok    = (r_req.site != '0) || i_cfg.wrap;
        left_addr  = (r_req.site != '0) ? ADDR_W'(site_len - LEN_W'(1)) : last_addr;
        right_ok   = (site_inc < i_cfg.chain_len) || i_cfg.wrap;
        right_addr = (site_inc < i_cfg.chain_len) ? ADDR_W'(site_inc) : '0;

        o_sts.is_fill  = (r_req.mode == MODE_ALL_UP) || (r_req.mode == MODE_ALL_DOWN)
                         || (r_req.mode == MODE_HALF);
        o_sts.refused  = (r_req.mode > MODE_SET)
                         || (((r_req.mode == MODE_TRIAL) || (r_req.mode == MODE_SET))
                             && !site_ok);
        o_sts.cnt_last = r_cnt >= last_addr;
        o_sts.cnt_top  = r_cnt == ADDR_W'(MAX_SITES - 1);
    end

    // Sweep counter for fills, recounts and the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clear) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_step) begin
            r_cnt <= r_cnt + ADDR_W'(1);
        end
    end

    // Memory port selection.
    assign addr_a = i_cmd.count_read ? r_cnt : site_addr;
    assign addr_b = i_cmd.rd_right ? right_addr : left_addr;

    always_comb begin
        if (i_cmd.fill_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt;
            mem_wdata = fill_val;
        end else begin
            mem_we    = i_cmd.item_update && write_item;
            mem_waddr = site_addr;
            mem_wdata = new_spin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_spins[addr_a];
        r_rd_b <= r_spins[addr_b];
        if (mem_we) begin
            r_spins[mem_waddr] <= mem_wdata;
        end
    end

    // Hold the old spin and the left neighbor while the right one is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_right) begin
            r_old  <= r_rd_a;
            r_left <= r_rd_b;
        end
    end

    // Acceptance test and incremental update of the totals.
    always_comb begin
        nb_left    = left_ok ? (r_left ? 3'sd1 : -3'sd1) : 3'sd0;
        nb_right   = right_ok ? (r_rd_b ? 3'sd1 : -3'sd1) : 3'sd0;
        nsum       = nb_left + nb_right;
        idx_w      = {{2{nsum[2]}}, nsum} + (r_old ? 5'd7 : 5'd2);
        thr_idx    = idx_w[THR_IDX_W-1:0];
        thr        = i_cfg.thresholds[thr_idx];
        rnd        = r_req.random_word & RND_MASK;
        flip       = rnd <= thr;
        new_spin   = (r_req.mode == MODE_TRIAL) ? (r_old ^ flip) : r_req.spin_value;
        write_item = (r_req.mode == MODE_TRIAL) ? flip : 1'b1;
        changed    = new_spin != r_old;
        nsum_w     = TOT_W'(nsum);
        bond_step  = r_old ? -(nsum_w <<< 1) : (nsum_w <<< 1);
        item_mag   = changed ? (r_mag + (r_old ? -TWO : TWO)) : r_mag;
        item_bond  = changed ? (r_bond + bond_step) : r_bond;
    end

    // Fill patterns and their closed-form totals.
    always_comb begin
        n_s    = TOT_W'(i_cfg.chain_len);
        wrap_s = TOT_W'(i_cfg.wrap);
        up_b   = n_s - ONE + wrap_s;
        case (r_req.mode)
            MODE_ALL_UP: begin
                fill_val   = 1'b1;
                fill_after = site_ok;
                fill_m     = n_s;
                fill_b     = up_b;
            end
            MODE_ALL_DOWN: begin
                fill_val   = 1'b0;
                fill_after = 1'b0;
                fill_m     = -n_s;
                fill_b     = up_b;
            end
            default: begin
                fill_val   = LEN_W'(r_cnt) < half_len;
                fill_after = site_ok && (site_len < half_len);
                fill_m     = i_cfg.chain_len[0] ? -ONE : '0;
                fill_b     = n_s - THREE - wrap_s;
            end
        endcase
        if (i_cmd.clear_pass) begin
            fill_val = 1'b1;
        end
    end

    // Recount accumulation, one site per cycle from read port A.
    always_comb begin
        if (r_cnt_first) begin
            n_acc_m = r_rd_a ? ONE : -ONE;
            n_acc_b = '0;
        end else begin
            n_acc_m = r_acc_m + (r_rd_a ? ONE : -ONE);
            n_acc_b = r_acc_b + ((r_rd_a == r_prev) ? ONE : -ONE);
        end
        cnt_b = n_acc_b;
        if (i_cfg.wrap) begin
            cnt_b = n_acc_b + ((r_rd_a == r_first) ? ONE : -ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= 1'b0;
        end else begin
            r_cnt_vld <= i_cmd.count_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_first <= i_cmd.count_read && (r_cnt == '0);
        if (r_cnt_vld) begin
            r_acc_m <= n_acc_m;
            r_acc_b <= n_acc_b;
            r_prev  <= r_rd_a;
            if (r_cnt_first) begin
                r_first <= r_rd_a;
            end
        end
    end

    // Totals selection and result formation.
    always_comb begin
        tot_load = 1'b1;
        tot_m    = r_mag;
        tot_b    = r_bond;
        if (i_cmd.item_update) begin
            tot_m = item_mag;
            tot_b = item_bond;
        end else if (i_cmd.fill_finish) begin
            tot_m = fill_m;
            tot_b = fill_b;
        end else if (i_cmd.clear_finish) begin
            tot_m = n_s;
            tot_b = up_b;
        end else if (i_cmd.count_finish) begin
            tot_m = n_acc_m;
            tot_b = cnt_b;
        end else begin
            tot_load = 1'b0;
        end

        res_load = i_cmd.item_update || i_cmd.fill_finish || i_cmd.refuse_finish;

        n_res.accepted      = i_cmd.item_update ? write_item : i_cmd.fill_finish;
        n_res.spin_after    = i_cmd.item_update ? new_spin
                              : (i_cmd.fill_finish ? fill_after : 1'b0);
        n_res.magnetization = (i_cfg.abs_mag && tot_m[TOT_W-1]) ? -tot_m : tot_m;
        n_res.bond_sum      = tot_b;
        n_res.item_refused  = i_cmd.refuse_finish;
    end

    always_ff @(posedge i_clk) begin
        if (tot_load) begin
            r_mag  <= tot_m;
            r_bond <= tot_b;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    // Result strobe, high for one cycle per finished request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res_load;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire
